// File: rtl/assert_macros.svh
// assertion macros shared by the rotation matrix rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ERM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ERM_ASSERT_IMP(label, ante, cons, msg) \
    `ERM_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: rtl/erm_pkg.sv
// shared types, constants and fixed point helpers for the rotation matrix
`default_nettype none

package erm_pkg;

    localparam int WORK_BITS = 30;
    localparam int ANGLE_W   = 16;
    localparam int OFFSET_W  = ANGLE_W - 2;
    localparam int ENTRY_W   = 16;

    typedef logic [WORK_BITS:0]          ufrac_t;
    typedef logic signed [WORK_BITS+1:0] q30_t;
    typedef logic signed [ENTRY_W-1:0]   entry_t;
    typedef logic signed [ANGLE_W-1:0]   angle_t;
    typedef logic [OFFSET_W:0]           offset_t;

    typedef struct packed {
        entry_t m11;
        entry_t m12;
        entry_t m13;
        entry_t m21;
        entry_t m22;
        entry_t m23;
        entry_t m31;
        entry_t m32;
        entry_t m33;
    } erm_matrix_t;

    // odd taylor coefficients of sin(pi/2 * x), q30
    localparam ufrac_t C1 = 31'd1686629713;
    localparam ufrac_t C3 = 31'd693598668;
    localparam ufrac_t C5 = 31'd85569306;
    localparam ufrac_t C7 = 31'd5026995;
    localparam ufrac_t C9 = 31'd172272;

    localparam ufrac_t  ONE      = {1'b1, {WORK_BITS{1'b0}}};
    localparam ufrac_t  HALF_LSB = {2'b01, {(WORK_BITS-1){1'b0}}};
    localparam q30_t    ONE_Q    = q30_t'({1'b0, ONE});
    localparam offset_t QLEN     = {1'b1, {OFFSET_W{1'b0}}};

    // unsigned q30 product, rounded half up
    function automatic ufrac_t umul_q(input ufrac_t a, input ufrac_t b);
        logic [2*WORK_BITS+1:0] prod;
        prod = {{(WORK_BITS+1){1'b0}}, a} * {{(WORK_BITS+1){1'b0}}, b}
             + {{(WORK_BITS+1){1'b0}}, HALF_LSB};
        return prod[2*WORK_BITS:WORK_BITS];
    endfunction

    // signed q30 product, rounded half away from zero
    function automatic q30_t smul_q(input q30_t a, input q30_t b);
        logic   neg;
        q30_t   abs_a;
        q30_t   abs_b;
        ufrac_t r;
        neg   = a[WORK_BITS+1] ^ b[WORK_BITS+1];
        abs_a = a[WORK_BITS+1] ? -a : a;
        abs_b = b[WORK_BITS+1] ? -b : b;
        r     = umul_q(abs_a[WORK_BITS:0], abs_b[WORK_BITS:0]);
        return neg ? -q30_t'({1'b0, r}) : q30_t'({1'b0, r});
    endfunction

endpackage

`default_nettype wire

// File: rtl/erm_sincos.sv
// pipelined sine and cosine of one binary angle, q30 results
`default_nettype none
`include "assert_macros.svh"

module erm_sincos (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  erm_pkg::angle_t angle,
    output logic            out_valid,
    output erm_pkg::q30_t   sin_q,
    output erm_pkg::q30_t   cos_q
);
    import erm_pkg::*;

    localparam int STAGES = 8;
    localparam int LANES  = 2;

    logic [STAGES-1:0] vld_reg;
    offset_t           t_reg   [6][LANES];
    logic [LANES-1:0]  neg_reg [7];
    ufrac_t            x2_reg  [4][LANES];
    ufrac_t            p_reg   [4][LANES];
    ufrac_t            mag_reg [LANES];
    q30_t              val_reg [LANES];

    logic [1:0]       quad;
    offset_t          t0;
    offset_t          t_next   [LANES];
    logic [LANES-1:0] neg_next;

    function automatic ufrac_t to_x(input offset_t t);
        return ufrac_t'(t) << (WORK_BITS - OFFSET_W);
    endfunction

    function automatic ufrac_t clamp_one(input ufrac_t v);
        return (v > ONE) ? ONE : v;
    endfunction

    // lane 0 sine, lane 1 cosine as sine of angle plus a quarter turn
    always_comb begin
        quad        = angle[ANGLE_W-1 -: 2];
        t0          = {1'b0, angle[OFFSET_W-1:0]};
        t_next[0]   = quad[0] ? QLEN - t0 : t0;
        neg_next[0] = quad[1];
        t_next[1]   = quad[0] ? t0 : QLEN - t0;
        neg_next[1] = quad[1] ^ quad[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= neg_next;
            for (int s = 1; s < 7; s++) begin
                neg_reg[s] <= neg_reg[s-1];
            end
            for (int l = 0; l < LANES; l++) begin
                t_reg[0][l] <= t_next[l];
                for (int s = 1; s < 6; s++) begin
                    t_reg[s][l] <= t_reg[s-1][l];
                end
                x2_reg[0][l] <= umul_q(to_x(t_reg[0][l]), to_x(t_reg[0][l]));
                for (int s = 1; s < 4; s++) begin
                    x2_reg[s][l] <= x2_reg[s-1][l];
                end
                // horner steps, one product per stage
                p_reg[0][l] <= C7 - umul_q(x2_reg[0][l], C9);
                p_reg[1][l] <= C5 - umul_q(x2_reg[1][l], p_reg[0][l]);
                p_reg[2][l] <= C3 - umul_q(x2_reg[2][l], p_reg[1][l]);
                p_reg[3][l] <= C1 - umul_q(x2_reg[3][l], p_reg[2][l]);
                mag_reg[l]  <= clamp_one(umul_q(to_x(t_reg[5][l]), p_reg[3][l]));
                val_reg[l]  <= neg_reg[6][l] ? -q30_t'({1'b0, mag_reg[l]})
                                             : q30_t'({1'b0, mag_reg[l]});
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign sin_q     = val_reg[0];
    assign cos_q     = val_reg[1];

    `ERM_ASSERT_IMP(a_sincos_bounded, out_valid,
        (sin_q <= ONE_Q) && (sin_q >= -ONE_Q) && (cos_q <= ONE_Q) && (cos_q >= -ONE_Q),
        "sine or cosine beyond unity")

endmodule

`default_nettype wire

// File: rtl/erm_matrix.sv
// pipelined products, sums and output rounding of the nine matrix entries
`default_nettype none

module erm_matrix #(
    parameter int FRACTION_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  erm_pkg::q30_t        sp,
    input  erm_pkg::q30_t        cp,
    input  erm_pkg::q30_t        so,
    input  erm_pkg::q30_t        co,
    input  erm_pkg::q30_t        sk,
    input  erm_pkg::q30_t        ck,
    output logic                 out_valid,
    output erm_pkg::erm_matrix_t result
);
    import erm_pkg::*;

    localparam int STAGES = 4;
    localparam int SHIFT  = WORK_BITS - FRACTION_BITS;

    typedef logic signed [WORK_BITS+2:0] sum_t;
    typedef logic [WORK_BITS+3:0]        wide_t;

    localparam wide_t RND = (wide_t'(1) << SHIFT) >> 1;
    localparam wide_t SAT = wide_t'(1) << FRACTION_BITS;

    logic [STAGES-1:0] vld_reg;

    q30_t spso_a_reg, cpso_a_reg;
    q30_t sp_a_reg, cp_a_reg, so_a_reg, co_a_reg, sk_a_reg, ck_a_reg;

    q30_t cpck_reg, spsosk_reg, cpsk_reg, spsock_reg, spco_reg, cosk_reg;
    q30_t cock_reg, spck_reg, cpsosk_reg, spsk_reg, cpsock_reg, cpco_reg;
    q30_t so_b_reg;

    sum_t        sum_reg [9];
    erm_matrix_t result_reg;

    // round to the output fraction, half away from zero, saturate to unity
    function automatic entry_t finish(input sum_t v);
        logic  neg;
        sum_t  abs_v;
        wide_t mag;
        neg   = v[WORK_BITS+2];
        abs_v = neg ? -v : v;
        mag   = (wide_t'(abs_v) + RND) >> SHIFT;
        if (mag > SAT) begin
            mag = SAT;
        end
        if (neg) begin
            mag = -mag;
        end
        return entry_t'(mag[ENTRY_W-1:0]);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            spso_a_reg <= smul_q(sp, so);
            cpso_a_reg <= smul_q(cp, so);
            sp_a_reg   <= sp;
            cp_a_reg   <= cp;
            so_a_reg   <= so;
            co_a_reg   <= co;
            sk_a_reg   <= sk;
            ck_a_reg   <= ck;

            cpck_reg   <= smul_q(cp_a_reg, ck_a_reg);
            spsosk_reg <= smul_q(spso_a_reg, sk_a_reg);
            cpsk_reg   <= smul_q(cp_a_reg, sk_a_reg);
            spsock_reg <= smul_q(spso_a_reg, ck_a_reg);
            spco_reg   <= smul_q(sp_a_reg, co_a_reg);
            cosk_reg   <= smul_q(co_a_reg, sk_a_reg);
            cock_reg   <= smul_q(co_a_reg, ck_a_reg);
            spck_reg   <= smul_q(sp_a_reg, ck_a_reg);
            cpsosk_reg <= smul_q(cpso_a_reg, sk_a_reg);
            spsk_reg   <= smul_q(sp_a_reg, sk_a_reg);
            cpsock_reg <= smul_q(cpso_a_reg, ck_a_reg);
            cpco_reg   <= smul_q(cp_a_reg, co_a_reg);
            so_b_reg   <= so_a_reg;

            sum_reg[0] <= sum_t'(cpck_reg) - sum_t'(spsosk_reg);
            sum_reg[1] <= -sum_t'(cpsk_reg) - sum_t'(spsock_reg);
            sum_reg[2] <= -sum_t'(spco_reg);
            sum_reg[3] <= sum_t'(cosk_reg);
            sum_reg[4] <= sum_t'(cock_reg);
            sum_reg[5] <= -sum_t'(so_b_reg);
            sum_reg[6] <= sum_t'(spck_reg) + sum_t'(cpsosk_reg);
            sum_reg[7] <= -sum_t'(spsk_reg) + sum_t'(cpsock_reg);
            sum_reg[8] <= sum_t'(cpco_reg);

            result_reg.m11 <= finish(sum_reg[0]);
            result_reg.m12 <= finish(sum_reg[1]);
            result_reg.m13 <= finish(sum_reg[2]);
            result_reg.m21 <= finish(sum_reg[3]);
            result_reg.m22 <= finish(sum_reg[4]);
            result_reg.m23 <= finish(sum_reg[5]);
            result_reg.m31 <= finish(sum_reg[6]);
            result_reg.m32 <= finish(sum_reg[7]);
            result_reg.m33 <= finish(sum_reg[8]);
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign result    = result_reg;

endmodule

`default_nettype wire

// File: rtl/euler_angle_rotation_matrix_top.sv
// top level of the phi omega kappa rotation matrix pipeline
//
// input channel: s_valid/s_ready carries the three binary angles, phi, omega and
// kappa, 16 bits each, two's complement, where 32768 is pi
// result channel: m_valid/m_ready carries the nine entries m11..m33 of the
// rotation matrix, signed with FRACTION_BITS fraction bits, saturated to +-1.0
// each input transfer gives exactly one result transfer, in order
// the result passes through eight stages of the sine polynomial and four of the
// matrix products and rounding, then through the output register
// throughput: one item per cycle while s_ready is high; every stage holds one item
// when the receiver stalls, the output register holds its result and a one-entry
// skid register takes the next one; s_ready drops only once the skid register is
// full and rises again the cycle after the output transfer frees it
// s_ready comes straight from a register, with no path from m_ready
// reset clears all valid bits, so nothing is presented until new input arrives
`default_nettype none
`include "assert_macros.svh"

module euler_angle_rotation_matrix_top #(
    parameter int FRACTION_BITS = 14
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  erm_pkg::angle_t s_primary_rotation,
    input  erm_pkg::angle_t s_secondary_rotation,
    input  erm_pkg::angle_t s_tertiary_rotation,
    output logic            m_valid,
    input  logic            m_ready,
    output erm_pkg::entry_t m_m11,
    output erm_pkg::entry_t m_m12,
    output erm_pkg::entry_t m_m13,
    output erm_pkg::entry_t m_m21,
    output erm_pkg::entry_t m_m22,
    output erm_pkg::entry_t m_m23,
    output erm_pkg::entry_t m_m31,
    output erm_pkg::entry_t m_m32,
    output erm_pkg::entry_t m_m33
);
    import erm_pkg::*;

    logic        en;
    logic [2:0]  lane_vld;
    q30_t        sp, cp, so, co, sk, ck;
    logic        mat_valid;
    erm_matrix_t mat_result;
    logic        out_fire;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    erm_matrix_t out_reg;
    erm_matrix_t skid_reg;

    assign en       = !skid_valid_reg;
    assign s_ready  = en;
    assign out_fire = out_valid_reg && m_ready;

    erm_sincos u_phi (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .angle     (s_primary_rotation),
        .out_valid (lane_vld[0]),
        .sin_q     (sp),
        .cos_q     (cp)
    );

    erm_sincos u_omega (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .angle     (s_secondary_rotation),
        .out_valid (lane_vld[1]),
        .sin_q     (so),
        .cos_q     (co)
    );

    erm_sincos u_kappa (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .angle     (s_tertiary_rotation),
        .out_valid (lane_vld[2]),
        .sin_q     (sk),
        .cos_q     (ck)
    );

    erm_matrix #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (&lane_vld),
        .sp        (sp),
        .cp        (cp),
        .so        (so),
        .co        (co),
        .sk        (sk),
        .ck        (ck),
        .out_valid (mat_valid),
        .result    (mat_result)
    );

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (mat_valid) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (mat_valid) begin
            if (out_valid_reg && !m_ready) begin
                skid_reg <= mat_result;
            end else begin
                out_reg <= mat_result;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_m11   = out_reg.m11;
    assign m_m12   = out_reg.m12;
    assign m_m13   = out_reg.m13;
    assign m_m21   = out_reg.m21;
    assign m_m22   = out_reg.m22;
    assign m_m23   = out_reg.m23;
    assign m_m31   = out_reg.m31;
    assign m_m32   = out_reg.m32;
    assign m_m33   = out_reg.m33;

    `ERM_ASSERT(a_lanes_aligned, (lane_vld == 3'b000) || (lane_vld == 3'b111),
        "angle lanes out of step")
    `ERM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held without an output entry")
    `ERM_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_valid_reg),
        $past(out_valid_reg && !m_ready), "skid filled without a stalled output")

endmodule

`default_nettype wire
